// ===== rtl/ole_pkg.sv =====
package ole_pkg;
   localparam int CAPACITY = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int LEN_W = $clog2(CAPACITY + 1);

   localparam logic [3:0] FN_FRONT_ADD = 4'd0;
   localparam logic [3:0] FN_BACK_ADD  = 4'd1;
   localparam logic [3:0] FN_FRONT_DEL = 4'd2;
   localparam logic [3:0] FN_BACK_DEL  = 4'd3;
   localparam logic [3:0] FN_INSERT    = 4'd4;
   localparam logic [3:0] FN_MIDDLE    = 4'd5;
   localparam logic [3:0] FN_DEL_VALUE = 4'd6;
   localparam logic [3:0] FN_REMOVE    = 4'd7;
   localparam logic [3:0] FN_SEARCH    = 4'd8;
   localparam logic [3:0] FN_REVERSE   = 4'd9;
   localparam logic [3:0] FN_READOUT   = 4'd10;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_EMPTY = 3'd1;
   localparam logic [2:0] ST_RANGE = 3'd2;
   localparam logic [2:0] ST_NOTFD = 3'd3;
   localparam logic [2:0] ST_FULL  = 3'd4;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [31:0] value;
      logic [4:0]         position;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] item_value;
      logic [4:0]         found_position;
      logic [4:0]         length_after;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SHIFT_UP, S_SCAN, S_SHIFT_DN, S_COMPACT, S_SWAP, S_READ, S_RESP
   } state_type;

   // datapath operation per cycle
   typedef enum logic [2:0] {
      OP_NONE, OP_LOAD, OP_UP, OP_SCAN, OP_DOWN, OP_COMPACT, OP_SWAP, OP_READ
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             done;   // current walk finished
      logic             hit;    // scan matched at current index
   } stat_type;
endpackage

// ===== rtl/ole_datapath.sv =====
module ole_datapath (
   input  logic              clock,
   input  logic              reset,
   input  ole_pkg::cmd_type  cmd,
   input  ole_pkg::req_type  req,
   output ole_pkg::stat_type stat,
   output ole_pkg::rsp_type  rsp_data,
   output logic              rsp_load
);
   localparam int IW = ole_pkg::IDX_W;
   localparam int LW = ole_pkg::LEN_W;
   localparam int DW = ole_pkg::DATA_WIDTH;

   logic [DW-1:0] mem [ole_pkg::CAPACITY];
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] i_ff, i_in, j_ff, j_in, tgt_ff, tgt_in;
   logic [3:0]    func_ff;
   logic [DW-1:0] val_ff;
   logic [2:0]    st_ff, st_in;
   logic [4:0]    fpos_ff, fpos_in;
   logic [DW-1:0] rd_i, rd_j, rd_im1;
   logic          wr_en, wr2_en;
   logic [IW-1:0] wr_a, wr2_a;
   logic [DW-1:0] wr_d, wr2_d;
   logic [LW-1:0] im1;

   assign im1 = i_ff - LW'(1);
   assign rd_i = mem[i_ff[IW-1:0]];
   assign rd_j = mem[j_ff[IW-1:0]];
   assign rd_im1 = mem[im1[IW-1:0]];

   always_comb begin
      len_in = len_ff; i_in = i_ff; j_in = j_ff; tgt_in = tgt_ff;
      st_in = st_ff; fpos_in = fpos_ff;
      wr_en = 1'b0; wr_a = i_ff[IW-1:0]; wr_d = val_ff;
      wr2_en = 1'b0; wr2_a = j_ff[IW-1:0]; wr2_d = rd_i;
      stat.done = 1'b0; stat.hit = 1'b0;
      rsp_load = 1'b0;
      rsp_data = '0;
      rsp_data.length_after = 5'(len_ff);
      rsp_data.status = st_ff;
      rsp_data.found_position = fpos_ff;
      rsp_data.last = 1'b1;
      case (cmd.op)
         ole_pkg::OP_LOAD: begin
            st_in = ole_pkg::ST_OK; fpos_in = '0;
            i_in = '0; j_in = '0; tgt_in = '0;
            case (req.func)
               ole_pkg::FN_FRONT_ADD, ole_pkg::FN_BACK_ADD, ole_pkg::FN_MIDDLE: begin
                  if (len_ff >= LW'(ole_pkg::CAPACITY)) st_in = ole_pkg::ST_FULL;
                  i_in = len_ff;
                  tgt_in = (req.func == ole_pkg::FN_FRONT_ADD) ? '0 :
                           (req.func == ole_pkg::FN_BACK_ADD) ? len_ff : (len_ff >> 1);
               end
               ole_pkg::FN_INSERT: begin
                  i_in = len_ff;
                  tgt_in = LW'(req.position) - LW'(1);
                  if (len_ff >= LW'(ole_pkg::CAPACITY)) st_in = ole_pkg::ST_FULL;
                  else if (req.position == 5'd0 ||
                           {1'b0, req.position} > 6'(len_ff) + 6'd1)
                     st_in = ole_pkg::ST_RANGE;
               end
               ole_pkg::FN_FRONT_DEL: begin
                  if (len_ff == '0) st_in = ole_pkg::ST_EMPTY;
               end
               ole_pkg::FN_BACK_DEL: begin
                  if (len_ff == '0) st_in = ole_pkg::ST_EMPTY;
                  else len_in = len_ff - LW'(1);
               end
               ole_pkg::FN_DEL_VALUE, ole_pkg::FN_SEARCH: st_in = ole_pkg::ST_NOTFD;
               ole_pkg::FN_REVERSE: j_in = len_ff - LW'(1);
               ole_pkg::FN_READOUT: if (len_ff == '0) st_in = ole_pkg::ST_EMPTY;
               default: ;
            endcase
         end
         ole_pkg::OP_UP: begin
            // move element i-1 to i until the gap reaches the target
            if (st_ff != ole_pkg::ST_OK) begin
               stat.done = 1'b1;
            end else if (i_ff == tgt_ff) begin
               wr_en = 1'b1; wr_a = i_ff[IW-1:0]; wr_d = val_ff;
               len_in = len_ff + LW'(1);
               stat.done = 1'b1;
            end else begin
               wr_en = 1'b1; wr_a = i_ff[IW-1:0]; wr_d = rd_im1;
               i_in = im1;
            end
         end
         ole_pkg::OP_SCAN: begin
            if (i_ff >= len_ff) stat.done = 1'b1;
            else if (rd_i == val_ff) begin
               stat.hit = 1'b1; stat.done = 1'b1;
               st_in = ole_pkg::ST_OK;
               if (func_ff == ole_pkg::FN_SEARCH) fpos_in = 5'(i_ff + LW'(1));
            end else i_in = i_ff + LW'(1);
         end
         ole_pkg::OP_DOWN: begin
            if (i_ff + LW'(1) >= len_ff) begin
               len_in = len_ff - LW'(1);
               stat.done = 1'b1;
            end else begin
               wr_en = 1'b1; wr_a = i_ff[IW-1:0]; wr_d = mem[IW'(i_ff + LW'(1))];
               i_in = i_ff + LW'(1);
            end
         end
         ole_pkg::OP_COMPACT: begin
            if (i_ff >= len_ff) begin
               len_in = j_ff; stat.done = 1'b1;
            end else begin
               if (rd_i != val_ff) begin
                  wr_en = 1'b1; wr_a = j_ff[IW-1:0]; wr_d = rd_i;
                  j_in = j_ff + LW'(1);
               end
               i_in = i_ff + LW'(1);
            end
         end
         ole_pkg::OP_SWAP: begin
            if (len_ff == '0 || i_ff >= j_ff) stat.done = 1'b1;
            else begin
               wr_en = 1'b1; wr_a = i_ff[IW-1:0]; wr_d = rd_j;
               wr2_en = 1'b1; wr2_a = j_ff[IW-1:0]; wr2_d = rd_i;
               i_in = i_ff + LW'(1); j_in = j_ff - LW'(1);
            end
         end
         ole_pkg::OP_READ: begin
            rsp_load = 1'b1;
            if (len_ff != '0) begin
               rsp_data.item_value = 32'(signed'(rd_i));
               rsp_data.last = (i_ff + LW'(1) == len_ff);
            end
            stat.done = rsp_data.last;
            i_in = i_ff + LW'(1);
         end
         default: ;
      endcase
      stat.len = len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) len_ff <= '0;
      else len_ff <= len_in;
      i_ff <= i_in; j_ff <= j_in; tgt_ff <= tgt_in;
      st_ff <= st_in; fpos_ff <= fpos_in;
      if (cmd.op == ole_pkg::OP_LOAD) begin
         func_ff <= req.func;
         val_ff <= req.value[DW-1:0];
      end
      if (wr_en) mem[wr_a] <= wr_d;
      if (wr2_en) mem[wr2_a] <= wr2_d;
   end
endmodule

// ===== rtl/ole_control.sv =====
module ole_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ole_pkg::req_type  req_data,
   input  ole_pkg::stat_type stat,
   input  logic              out_busy,
   output ole_pkg::cmd_type  cmd,
   output logic              rsp_go
);
   ole_pkg::state_type state_ff, state_in;
   logic [3:0] func_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ole_pkg::S_IDLE;
      else state_ff <= state_in;
      if (state_ff == ole_pkg::S_IDLE) func_ff <= req_data.func;
   end

   always_comb begin
      state_in = state_ff;
      cmd.op = ole_pkg::OP_NONE;
      req_stall = 1'b1;
      rsp_go = 1'b0;
      case (state_ff)
         ole_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op = ole_pkg::OP_LOAD;
               case (req_data.func)
                  ole_pkg::FN_FRONT_ADD, ole_pkg::FN_BACK_ADD, ole_pkg::FN_MIDDLE,
                  ole_pkg::FN_INSERT:
                     state_in = ole_pkg::S_SHIFT_UP;
                  ole_pkg::FN_FRONT_DEL: state_in = ole_pkg::S_SHIFT_DN;
                  ole_pkg::FN_DEL_VALUE, ole_pkg::FN_SEARCH: state_in = ole_pkg::S_SCAN;
                  ole_pkg::FN_REMOVE: state_in = ole_pkg::S_COMPACT;
                  ole_pkg::FN_REVERSE: state_in = ole_pkg::S_SWAP;
                  ole_pkg::FN_READOUT: state_in = ole_pkg::S_READ;
                  default: state_in = ole_pkg::S_RESP;
               endcase
            end
         end
         ole_pkg::S_SHIFT_UP: begin
            // status was settled at load; the walk ends at once on full or bad position
            cmd.op = ole_pkg::OP_UP;
            if (stat.done) state_in = ole_pkg::S_RESP;
         end
         ole_pkg::S_SHIFT_DN: begin
            if (stat.len == '0) state_in = ole_pkg::S_RESP;
            else begin
               cmd.op = ole_pkg::OP_DOWN;
               if (stat.done) state_in = ole_pkg::S_RESP;
            end
         end
         ole_pkg::S_SCAN: begin
            cmd.op = ole_pkg::OP_SCAN;
            if (stat.done) begin
               if (stat.hit && func_ff == ole_pkg::FN_DEL_VALUE)
                  state_in = ole_pkg::S_SHIFT_DN;
               else state_in = ole_pkg::S_RESP;
            end
         end
         ole_pkg::S_COMPACT: begin
            cmd.op = ole_pkg::OP_COMPACT;
            if (stat.done) state_in = ole_pkg::S_RESP;
         end
         ole_pkg::S_SWAP: begin
            cmd.op = ole_pkg::OP_SWAP;
            if (stat.done) state_in = ole_pkg::S_RESP;
         end
         ole_pkg::S_READ: begin
            if (!out_busy) begin
               cmd.op = ole_pkg::OP_READ;
               if (stat.done) state_in = ole_pkg::S_IDLE;
            end
         end
         ole_pkg::S_RESP: begin
            if (!out_busy) begin
               rsp_go = 1'b1;
               state_in = ole_pkg::S_IDLE;
            end
         end
         default: state_in = ole_pkg::S_IDLE;
      endcase
   end
endmodule

// ===== rtl/ordered_list_engine.sv =====
// channel | ports                          | payload
// request | req_valid, req_stall, req_data | ole_pkg::req_type
// result  | rsp_valid, rsp_stall, rsp_data | ole_pkg::rsp_type
// One command at a time. Add and insert shift elements up (ending at once when
// full or out of range), front delete shifts the rest down, back delete drops
// the length only, search scans, delete by value scans then shifts down,
// remove-all compacts, reverse swaps pairs from both ends; each walk handles one
// element per cycle, readout only while the result is not stalled.
// Reset clears the length, the sequencer state and the result valid flag. A
// stalled result holds in the output register and holds the sequencer.
module ordered_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ole_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ole_pkg::rsp_type rsp_data
);
   ole_pkg::cmd_type  cmd;
   ole_pkg::stat_type stat;
   ole_pkg::rsp_type  dp_rsp, rsp_ff;
   logic dp_load, rsp_go, valid_ff, out_busy;

   assign out_busy = valid_ff && rsp_stall;

   ole_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .stat, .out_busy, .cmd, .rsp_go
   );

   ole_datapath u_dp (
      .clock, .reset, .cmd, .req(req_data), .stat,
      .rsp_data(dp_rsp), .rsp_load(dp_load)
   );

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (dp_load || rsp_go) valid_ff <= 1'b1;
      else if (!rsp_stall) valid_ff <= 1'b0;
      if (dp_load || rsp_go) rsp_ff <= dp_rsp;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = rsp_ff;
endmodule

// ===== rtl/ole_checker.sv =====
module ole_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ole_pkg::rsp_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.length_after <= 5'(ole_pkg::CAPACITY))
      else $error("length beyond capacity");
   a_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.item_value != 32'sd0 |-> rsp_data.status == ole_pkg::ST_OK)
      else $error("item value on a non-ok result");
   a_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ole_pkg::ST_OK |-> rsp_data.last)
      else $error("error status not last");
   logic unused;
   assign unused = req_valid ^ req_stall;
endmodule

bind ordered_list_engine ole_checker u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
